[rtl/core/rsh_pkg.sv]
// ----------------------------------------------------------------------------
// rsh_pkg: shared types and constants of the ray and sphere hit shader
// Transaction payloads, register indexes and the sideband groups that ride
// along the square root and divider pipelines.
// ----------------------------------------------------------------------------
package rsh_pkg;

    // input transaction: one ray, signed Q8.8
    typedef struct packed {
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic signed [15:0] origin_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
    } ray_t;

    // output transaction: hit flag, distance (Q8.8), shading glyph
    typedef struct packed {
        logic               hit;
        logic signed [15:0] distance;
        logic [3:0]         glyph_index;
    } result_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_CENTER_Z = 2'd2,
        CFG_RADIUS   = 2'd3
    } cfg_idx_t;

    localparam logic signed [15:0] CENTER_X_RST = 16'sd0;
    localparam logic signed [15:0] CENTER_Y_RST = 16'sd0;
    localparam logic signed [15:0] CENTER_Z_RST = -16'sd256;
    localparam logic [14:0]        RADIUS_RST   = 15'd128;

    // distance codes
    localparam logic signed [15:0] MISS_DIST = -16'sd256;
    localparam logic signed [15:0] DIST_MAX  = 16'sh7FFF;
    localparam logic signed [15:0] DIST_MIN  = 16'sh8000;

    // ray geometry carried next to the discriminant
    typedef struct packed {
        logic [31:0]        a;
        logic signed [34:0] half_b;
        logic signed [16:0] ocx;
        logic signed [16:0] ocy;
        logic signed [16:0] ocz;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [15:0] dz;
    } geo_t;

    // sideband of the discriminant square root
    typedef struct packed {
        logic miss;
        geo_t geo;
    } sq1_side_t;

    // sideband of the distance divider
    typedef struct packed {
        logic               miss;
        logic               neg;
        logic               ovf;
        logic signed [16:0] ocx;
        logic signed [16:0] ocy;
        logic signed [16:0] ocz;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [15:0] dz;
    } div1_side_t;

    // sideband of the normal length square root
    typedef struct packed {
        logic               hit;
        logic signed [15:0] tq;
        logic signed [31:0] nx;
    } sq2_side_t;

    // sideband of the glyph divider
    typedef struct packed {
        logic               hit;
        logic               zero_len;
        logic signed [15:0] tq;
    } div2_side_t;

endpackage

[rtl/core/rsh_isqrt.sv]
// ----------------------------------------------------------------------------
// rsh_isqrt: pipelined integer square root
// Floor square root, one result bit per register stage, with a sideband
// vector that travels alongside. The whole pipe advances on en.
// ----------------------------------------------------------------------------
module rsh_isqrt
#(
    parameter int IN_W   = 64,
    parameter int SIDE_W = 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [IN_W-1:0]     in_val,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic [IN_W/2-1:0]   out_root,
    output logic [SIDE_W-1:0]   out_side
);

    localparam int STEPS = IN_W / 2;

    logic [IN_W-1:0]   v_reg    [STEPS];
    logic [IN_W-1:0]   res_reg  [STEPS];
    logic [SIDE_W-1:0] side_reg [STEPS];
    logic [STEPS-1:0]  vld_reg;

    logic [IN_W-1:0]   v_next    [STEPS];
    logic [IN_W-1:0]   res_next  [STEPS];
    logic [SIDE_W-1:0] side_next [STEPS];
    logic [STEPS-1:0]  vld_next;

    // one trial subtraction per stage
    always_comb
    begin
        logic [IN_W-1:0] v_cur;
        logic [IN_W-1:0] res_cur;
        logic [IN_W-1:0] trial;
        logic [IN_W-1:0] bit_w;
        for (int k = 0; k < STEPS; k++)
        begin
            if (k == 0)
            begin
                v_cur        = in_val;
                res_cur      = '0;
                side_next[k] = in_side;
                vld_next[k]  = in_valid;
            end
            else
            begin
                v_cur        = v_reg[k-1];
                res_cur      = res_reg[k-1];
                side_next[k] = side_reg[k-1];
                vld_next[k]  = vld_reg[k-1];
            end
            bit_w = IN_W'(1) << (IN_W - 2 - 2 * k);
            trial = res_cur + bit_w;
            if (v_cur >= trial)
            begin
                v_next[k]   = v_cur - trial;
                res_next[k] = (res_cur >> 1) + bit_w;
            end
            else
            begin
                v_next[k]   = v_cur;
                res_next[k] = res_cur >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg    <= v_next;
            res_reg  <= res_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = vld_reg[STEPS-1];
    assign out_root  = res_reg[STEPS-1][IN_W/2-1:0];
    assign out_side  = side_reg[STEPS-1];

endmodule

[rtl/core/rsh_div.sv]
// ----------------------------------------------------------------------------
// rsh_div: pipelined restoring divider
// One quotient bit per register stage. The dividend must stay below the
// divisor shifted by the quotient width. A sideband vector rides along.
// ----------------------------------------------------------------------------
module rsh_div
#(
    parameter int NUM_W  = 43,
    parameter int DEN_W  = 32,
    parameter int Q_W    = 17,
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [Q_W-1:0]    out_quot,
    output logic [SIDE_W-1:0] out_side
);

    localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [CW-1:0]     rem_reg  [Q_W];
    logic [DEN_W-1:0]  den_reg  [Q_W];
    logic [Q_W-1:0]    q_reg    [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];
    logic [Q_W-1:0]    vld_reg;

    logic [CW-1:0]     rem_next  [Q_W];
    logic [DEN_W-1:0]  den_next  [Q_W];
    logic [Q_W-1:0]    q_next    [Q_W];
    logic [SIDE_W-1:0] side_next [Q_W];
    logic [Q_W-1:0]    vld_next;

    // stage k decides quotient bit Q_W-1-k
    always_comb
    begin
        logic [CW-1:0]    rem_cur;
        logic [Q_W-1:0]   q_cur;
        logic [CW-1:0]    shifted;
        for (int k = 0; k < Q_W; k++)
        begin
            if (k == 0)
            begin
                rem_cur      = CW'(in_num);
                q_cur        = '0;
                den_next[k]  = in_den;
                side_next[k] = in_side;
                vld_next[k]  = in_valid;
            end
            else
            begin
                rem_cur      = rem_reg[k-1];
                q_cur        = q_reg[k-1];
                den_next[k]  = den_reg[k-1];
                side_next[k] = side_reg[k-1];
                vld_next[k]  = vld_reg[k-1];
            end
            shifted = CW'(den_next[k]) << (Q_W - 1 - k);
            if (rem_cur >= shifted)
            begin
                rem_next[k] = rem_cur - shifted;
                q_next[k]   = q_cur | (Q_W'(1) << (Q_W - 1 - k));
            end
            else
            begin
                rem_next[k] = rem_cur;
                q_next[k]   = q_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            den_reg  <= den_next;
            q_reg    <= q_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = vld_reg[Q_W-1];
    assign out_quot  = q_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

[rtl/core/ray_sphere_hit_shader.sv]
// ----------------------------------------------------------------------------
// ray_sphere_hit_shader: ray against configured sphere, distance and glyph
// Built around the two 31/32-stage square roots and the 17-stage distance
// divider. Throughput: one ray per cycle while ray_stall is low.
// Reset clears all valid bits and loads the default sphere: center (0,0,-1.0),
// radius 0.5.
// ----------------------------------------------------------------------------
module ray_sphere_hit_shader
    import rsh_pkg::*;
#(
    parameter int GLYPH_COUNT = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        ray_valid,
    output logic        ray_stall,
    input  ray_t        ray_data,
    output logic        hit_valid,
    input  logic        hit_stall,
    output result_t     hit_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int GW  = $clog2(GLYPH_COUNT);
    localparam int NW2 = 33 + GW;
    localparam logic [GW-1:0] GMAX = GW'(GLYPH_COUNT - 1);

    // configuration
    logic signed [15:0] cx_reg, cy_reg, cz_reg;
    logic [14:0]        rad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg  <= CENTER_X_RST;
            cy_reg  <= CENTER_Y_RST;
            cz_reg  <= CENTER_Z_RST;
            rad_reg <= RADIUS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CENTER_X: cx_reg  <= cfg_data;
                CFG_CENTER_Y: cy_reg  <= cfg_data;
                CFG_CENTER_Z: cz_reg  <= cfg_data;
                CFG_RADIUS:   rad_reg <= cfg_data[14:0];
            endcase
        end
    end

    // pipeline advance: frozen only while the skid register holds a result
    logic en;
    logic skid_vld_reg;
    assign en        = !skid_vld_reg;
    assign ray_stall = skid_vld_reg;

    logic [6:0] vld_a_reg;
    logic [2:0] vld_b_reg;
    logic [5:0] vld_c_reg;
    logic [1:0] vld_d_reg;

    // stage 1: offset from center, radius squared
    logic signed [16:0] ocx1_reg, ocy1_reg, ocz1_reg;
    logic signed [15:0] dx1_reg, dy1_reg, dz1_reg;
    logic [29:0]        r2_1_reg;
    // stage 2: products
    logic [30:0]        sxx2_reg, syy2_reg, szz2_reg;
    logic signed [32:0] pdx2_reg, pdy2_reg, pdz2_reg;
    logic signed [32:0] pyz2_reg, pzy2_reg, pzx2_reg, pxz2_reg, pxy2_reg, pyx2_reg;
    logic signed [16:0] ocx2_reg, ocy2_reg, ocz2_reg;
    logic signed [15:0] dx2_reg, dy2_reg, dz2_reg;
    logic [29:0]        r2_2_reg;
    // stage 3: sums
    geo_t               geo3_reg;
    logic signed [33:0] cxp3_reg, cyp3_reg, czp3_reg;
    logic [29:0]        r2_3_reg;
    // stage 4: magnitudes, a*r^2
    geo_t               geo4_reg;
    logic [31:0]        mx4_reg, my4_reg, mz4_reg;
    logic [61:0]        ar2_4_reg;
    // stage 5: squared cross product terms
    geo_t               geo5_reg;
    logic [63:0]        sqx5_reg, sqy5_reg, sqz5_reg;
    logic [61:0]        ar2_5_reg;
    // stage 6: |oc x d|^2
    geo_t               geo6_reg;
    logic [65:0]        cr2_6_reg;
    logic [61:0]        ar2_6_reg;
    // stage 7: discriminant
    sq1_side_t          side7_reg;
    logic [61:0]        disc7_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1
            ocx1_reg <= 17'(ray_data.origin_x) - 17'(cx_reg);
            ocy1_reg <= 17'(ray_data.origin_y) - 17'(cy_reg);
            ocz1_reg <= 17'(ray_data.origin_z) - 17'(cz_reg);
            dx1_reg  <= ray_data.dir_x;
            dy1_reg  <= ray_data.dir_y;
            dz1_reg  <= ray_data.dir_z;
            r2_1_reg <= 30'(rad_reg) * 30'(rad_reg);
            // stage 2
            sxx2_reg <= 31'(32'(dx1_reg) * 32'(dx1_reg));
            syy2_reg <= 31'(32'(dy1_reg) * 32'(dy1_reg));
            szz2_reg <= 31'(32'(dz1_reg) * 32'(dz1_reg));
            pdx2_reg <= 33'(ocx1_reg) * 33'(dx1_reg);
            pdy2_reg <= 33'(ocy1_reg) * 33'(dy1_reg);
            pdz2_reg <= 33'(ocz1_reg) * 33'(dz1_reg);
            pyz2_reg <= 33'(ocy1_reg) * 33'(dz1_reg);
            pzy2_reg <= 33'(ocz1_reg) * 33'(dy1_reg);
            pzx2_reg <= 33'(ocz1_reg) * 33'(dx1_reg);
            pxz2_reg <= 33'(ocx1_reg) * 33'(dz1_reg);
            pxy2_reg <= 33'(ocx1_reg) * 33'(dy1_reg);
            pyx2_reg <= 33'(ocy1_reg) * 33'(dx1_reg);
            ocx2_reg <= ocx1_reg;
            ocy2_reg <= ocy1_reg;
            ocz2_reg <= ocz1_reg;
            dx2_reg  <= dx1_reg;
            dy2_reg  <= dy1_reg;
            dz2_reg  <= dz1_reg;
            r2_2_reg <= r2_1_reg;
            // stage 3
            geo3_reg.a      <= 32'(sxx2_reg) + 32'(syy2_reg) + 32'(szz2_reg);
            geo3_reg.half_b <= 35'(pdx2_reg) + 35'(pdy2_reg) + 35'(pdz2_reg);
            geo3_reg.ocx    <= ocx2_reg;
            geo3_reg.ocy    <= ocy2_reg;
            geo3_reg.ocz    <= ocz2_reg;
            geo3_reg.dx     <= dx2_reg;
            geo3_reg.dy     <= dy2_reg;
            geo3_reg.dz     <= dz2_reg;
            cxp3_reg <= 34'(pyz2_reg) - 34'(pzy2_reg);
            cyp3_reg <= 34'(pzx2_reg) - 34'(pxz2_reg);
            czp3_reg <= 34'(pxy2_reg) - 34'(pyx2_reg);
            r2_3_reg <= r2_2_reg;
            // stage 4
            geo4_reg  <= geo3_reg;
            mx4_reg   <= cxp3_reg[33] ? 32'(-cxp3_reg) : 32'(cxp3_reg);
            my4_reg   <= cyp3_reg[33] ? 32'(-cyp3_reg) : 32'(cyp3_reg);
            mz4_reg   <= czp3_reg[33] ? 32'(-czp3_reg) : 32'(czp3_reg);
            ar2_4_reg <= 62'(geo3_reg.a) * 62'(r2_3_reg);
            // stage 5
            geo5_reg  <= geo4_reg;
            sqx5_reg  <= 64'(mx4_reg) * 64'(mx4_reg);
            sqy5_reg  <= 64'(my4_reg) * 64'(my4_reg);
            sqz5_reg  <= 64'(mz4_reg) * 64'(mz4_reg);
            ar2_5_reg <= ar2_4_reg;
            // stage 6
            geo6_reg  <= geo5_reg;
            cr2_6_reg <= 66'(sqx5_reg) + 66'(sqy5_reg) + 66'(sqz5_reg);
            ar2_6_reg <= ar2_5_reg;
            // stage 7: zero direction or negative discriminant is a miss
            side7_reg.geo  <= geo6_reg;
            side7_reg.miss <= (geo6_reg.a == 32'd0) || (cr2_6_reg > 66'(ar2_6_reg));
            disc7_reg      <= ar2_6_reg - cr2_6_reg[61:0];
        end
    end

    // square root of the discriminant
    logic        sq1_vld;
    logic [30:0] root1;
    sq1_side_t   sq1_side;

    rsh_isqrt
    #(
        .IN_W   (62),
        .SIDE_W ($bits(sq1_side_t))
    )
    u_sqrt_disc
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld_a_reg[6]),
        .in_val    (disc7_reg),
        .in_side   (side7_reg),
        .out_valid (sq1_vld),
        .out_root  (root1),
        .out_side  (sq1_side)
    );

    // stages 8-10: numerator, magnitude, overflow check
    logic signed [35:0] num8_reg;
    sq1_side_t          side8_reg;
    logic [34:0]        nmag9_reg;
    logic               neg9_reg;
    sq1_side_t          side9_reg;
    logic [42:0]        ddnd10_reg;
    logic [31:0]        dvsr10_reg;
    div1_side_t         side10_reg;
    logic               ovf9;

    assign ovf9 = 41'(nmag9_reg) >= {side9_reg.geo.a, 9'b0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num8_reg  <= -36'(sq1_side.geo.half_b) - 36'(root1);
            side8_reg <= sq1_side;
            nmag9_reg <= num8_reg[35] ? 35'(-num8_reg) : 35'(num8_reg);
            neg9_reg  <= num8_reg[35];
            side9_reg <= side8_reg;
            ddnd10_reg      <= ovf9 ? '0 : {nmag9_reg, 8'b0};
            dvsr10_reg      <= side9_reg.geo.a;
            side10_reg.miss <= side9_reg.miss;
            side10_reg.neg  <= neg9_reg;
            side10_reg.ovf  <= ovf9;
            side10_reg.ocx  <= side9_reg.geo.ocx;
            side10_reg.ocy  <= side9_reg.geo.ocy;
            side10_reg.ocz  <= side9_reg.geo.ocz;
            side10_reg.dx   <= side9_reg.geo.dx;
            side10_reg.dy   <= side9_reg.geo.dy;
            side10_reg.dz   <= side9_reg.geo.dz;
        end
    end

    // distance divider: |num| * 256 / a
    logic        div1_vld;
    logic [16:0] quot1;
    div1_side_t  div1_side;

    rsh_div
    #(
        .NUM_W  (43),
        .DEN_W  (32),
        .Q_W    (17),
        .SIDE_W ($bits(div1_side_t))
    )
    u_div_dist
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld_b_reg[2]),
        .in_num    (ddnd10_reg),
        .in_den    (dvsr10_reg),
        .in_side   (side10_reg),
        .out_valid (div1_vld),
        .out_quot  (quot1),
        .out_side  (div1_side)
    );

    // saturate distance, decide hit
    logic signed [15:0] tq11_next;
    logic               hit11_next;

    always_comb
    begin
        hit11_next = 1'b0;
        if (div1_side.miss)
            tq11_next = MISS_DIST;
        else if (div1_side.neg)
        begin
            if (div1_side.ovf || quot1 > 17'd32768)
                tq11_next = DIST_MIN;
            else
                tq11_next = 16'(17'd0 - quot1);
        end
        else
        begin
            if (div1_side.ovf || quot1 > 17'd32767)
                tq11_next = DIST_MAX;
            else
                tq11_next = quot1[15:0];
            hit11_next = div1_side.ovf || (quot1 != 17'd0);
        end
    end

    // stages 11-16: hit point normal and its squared length
    logic signed [15:0] tq11_reg;
    logic               hit11_reg;
    logic signed [16:0] ocx11_reg, ocy11_reg, ocz11_reg;
    logic signed [15:0] dx11_reg, dy11_reg, dz11_reg;
    logic signed [31:0] px12_reg, py12_reg, pz12_reg;
    logic signed [16:0] ocx12_reg, ocy12_reg, ocz12_reg;
    sq2_side_t          s12_reg, s13_reg, s14_reg, s15_reg, s16_reg;
    logic signed [31:0] nx13_reg, ny13_reg, nz13_reg;
    logic [30:0]        mnx14_reg, mny14_reg, mnz14_reg;
    logic [61:0]        sqx15_reg, sqy15_reg, sqz15_reg;
    logic [63:0]        len2_16_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tq11_reg  <= tq11_next;
            hit11_reg <= hit11_next;
            ocx11_reg <= div1_side.ocx;
            ocy11_reg <= div1_side.ocy;
            ocz11_reg <= div1_side.ocz;
            dx11_reg  <= div1_side.dx;
            dy11_reg  <= div1_side.dy;
            dz11_reg  <= div1_side.dz;
            // stage 12: d * t
            px12_reg  <= 32'(dx11_reg) * 32'(tq11_reg);
            py12_reg  <= 32'(dy11_reg) * 32'(tq11_reg);
            pz12_reg  <= 32'(dz11_reg) * 32'(tq11_reg);
            ocx12_reg <= ocx11_reg;
            ocy12_reg <= ocy11_reg;
            ocz12_reg <= ocz11_reg;
            s12_reg.hit <= hit11_reg;
            s12_reg.tq  <= tq11_reg;
            s12_reg.nx  <= '0;
            // stage 13: n = oc*256 + d*t
            nx13_reg <= (32'(ocx12_reg) <<< 8) + px12_reg;
            ny13_reg <= (32'(ocy12_reg) <<< 8) + py12_reg;
            nz13_reg <= (32'(ocz12_reg) <<< 8) + pz12_reg;
            s13_reg  <= s12_reg;
            // stage 14: magnitudes
            mnx14_reg  <= nx13_reg[31] ? 31'(-nx13_reg) : 31'(nx13_reg);
            mny14_reg  <= ny13_reg[31] ? 31'(-ny13_reg) : 31'(ny13_reg);
            mnz14_reg  <= nz13_reg[31] ? 31'(-nz13_reg) : 31'(nz13_reg);
            s14_reg.hit <= s13_reg.hit;
            s14_reg.tq  <= s13_reg.tq;
            s14_reg.nx  <= nx13_reg;
            // stage 15: squares
            sqx15_reg <= 62'(mnx14_reg) * 62'(mnx14_reg);
            sqy15_reg <= 62'(mny14_reg) * 62'(mny14_reg);
            sqz15_reg <= 62'(mnz14_reg) * 62'(mnz14_reg);
            s15_reg   <= s14_reg;
            // stage 16: |n|^2
            len2_16_reg <= 64'(sqx15_reg) + 64'(sqy15_reg) + 64'(sqz15_reg);
            s16_reg     <= s15_reg;
        end
    end

    // length of the normal
    logic        sq2_vld;
    logic [31:0] len;
    sq2_side_t   sq2_side;

    rsh_isqrt
    #(
        .IN_W   (64),
        .SIDE_W ($bits(sq2_side_t))
    )
    u_sqrt_len
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld_c_reg[5]),
        .in_val    (len2_16_reg),
        .in_side   (s16_reg),
        .out_valid (sq2_vld),
        .out_root  (len),
        .out_side  (sq2_side)
    );

    // clamp nx to [-len, len] and shift to [0, 2*len]
    logic [32:0]        base17_next;
    logic signed [33:0] nx34;
    logic signed [33:0] len34;

    always_comb
    begin
        nx34  = 34'(sq2_side.nx);
        len34 = $signed(34'(len));
        if (nx34 > len34)
            base17_next = {len, 1'b0};
        else if (nx34 < -len34)
            base17_next = '0;
        else
            base17_next = 33'(nx34 + len34);
    end

    // stages 17-18: glyph numerator and denominator
    logic [32:0]    base17_reg;
    logic [32:0]    den17_reg;
    div2_side_t     side17_reg;
    logic [NW2-1:0] num18_reg;
    logic [32:0]    den18_reg;
    div2_side_t     side18_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            base17_reg          <= base17_next;
            den17_reg           <= {len, 1'b0};
            side17_reg.hit      <= sq2_side.hit;
            side17_reg.zero_len <= (len == 32'd0);
            side17_reg.tq       <= sq2_side.tq;
            num18_reg  <= NW2'(base17_reg) * NW2'(GMAX);
            den18_reg  <= den17_reg;
            side18_reg <= side17_reg;
        end
    end

    // glyph divider
    logic          div2_vld;
    logic [GW-1:0] quot2;
    div2_side_t    div2_side;

    rsh_div
    #(
        .NUM_W  (NW2),
        .DEN_W  (33),
        .Q_W    (GW),
        .SIDE_W ($bits(div2_side_t))
    )
    u_div_glyph
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld_d_reg[1]),
        .in_num    (num18_reg),
        .in_den    (den18_reg),
        .in_side   (side18_reg),
        .out_valid (div2_vld),
        .out_quot  (quot2),
        .out_side  (div2_side)
    );

    // final result; glyph saturates at 15
    result_t    done_res;
    logic [8:0] q9;

    always_comb
    begin
        q9                   = 9'(quot2);
        done_res.hit         = div2_side.hit;
        done_res.distance    = div2_side.tq;
        done_res.glyph_index = 4'd0;
        if (div2_side.hit && !div2_side.zero_len)
            done_res.glyph_index = (q9 > 9'd15) ? 4'd15 : q9[3:0];
    end

    // valid bits of the inline stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= '0;
            vld_b_reg <= '0;
            vld_c_reg <= '0;
            vld_d_reg <= '0;
        end
        else if (en)
        begin
            vld_a_reg <= {vld_a_reg[5:0], ray_valid};
            vld_b_reg <= {vld_b_reg[1:0], sq1_vld};
            vld_c_reg <= {vld_c_reg[4:0], div1_vld};
            vld_d_reg <= {vld_d_reg[0], sq2_vld};
        end
    end

    // output register plus skid register
    logic    out_vld_reg;
    result_t out_reg;
    result_t skid_reg;
    logic    out_take;

    assign out_take = out_vld_reg && !hit_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (out_take)
                skid_vld_reg <= 1'b0;
        end
        else if (div2_vld)
        begin
            if (out_vld_reg && !out_take)
                skid_vld_reg <= 1'b1;
            else
                out_vld_reg <= 1'b1;
        end
        else if (out_take)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (out_take)
                out_reg <= skid_reg;
        end
        else if (div2_vld)
        begin
            if (out_vld_reg && !out_take)
                skid_reg <= done_res;
            else
                out_reg <= done_res;
        end
    end

    assign hit_valid = out_vld_reg;
    assign hit_data  = out_reg;

endmodule
